FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by rstree_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication: when ante holds, cons must hold at the following edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: src/rstree_pkg.sv
// ---------------------------------------------------------------------------
// rstree_pkg
// Sizes, codes and controller/datapath interface types for the sum tree.
// ---------------------------------------------------------------------------
package rstree_pkg;

   localparam int LEAF_COUNT  = 1024;
   localparam int LEVELS      = $clog2(LEAF_COUNT);
   localparam int TREE_LEAVES = 1 << LEVELS;
   localparam int TREE_NODES  = 2 * TREE_LEAVES;
   localparam int NODE_W      = LEVELS + 1;   // node index 1 .. TREE_NODES-1
   localparam int SPAN_W      = NODE_W + 1;   // range bound may reach TREE_NODES
   localparam int POS_W       = 11;
   localparam int DATA_W      = 32;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic ST_OK  = 1'b0;
   localparam logic ST_BAD = 1'b1;

   typedef struct packed {
      logic capture;
      logic clear_step;
      logic leaf_write;
      logic sib_read;
      logic parent_write;
      logic range_read;
      logic range_accum;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic bad_item;
      logic is_query;
      logic node_is_root;
      logic range_empty;
      logic slot_free;
   } stat_type;

endpackage

FILE: src/range_sum_tree_core.sv
// ---------------------------------------------------------------------------
// range_sum_tree_core
// Segment sum tree over 1024 leaves with point writes and range queries.
// ---------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat is a write (operation 0: set leaf at position to
//   leaf_value) or a query (operation 1: sum leaves range_start..range_end,
//   1-based, inclusive). Each beat yields exactly one rsp_ beat, in order,
//   carrying range_total (zero for writes and rejected beats) and status.
//   Sequence: a write does one leaf store, then a sibling read and a parent
//   store per level up to the root. A query reads and accumulates one level
//   at a time until its range is empty. A rejected beat goes straight to its
//   result, which is loaded when the output slot is free.
//   Throughput: one item at a time; req_ready rises the cycle after a result
//   is loaded, and stays low while an item is in flight.
//   Reset: a clearing pass zeroes all 2048 entries of the node store, one
//   entry a cycle; req_ready stays low until it ends.
//   Stall: a finished result waits in the output register; the next beat is
//   still accepted, and its result is held back until the slot frees.
// ---------------------------------------------------------------------------
module range_sum_tree_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_operation,
   input  logic        [rstree_pkg::POS_W-1:0]  req_position,
   input  logic signed [rstree_pkg::DATA_W-1:0] req_leaf_value,
   input  logic        [rstree_pkg::POS_W-1:0]  req_range_start,
   input  logic        [rstree_pkg::POS_W-1:0]  req_range_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [rstree_pkg::DATA_W-1:0] rsp_range_total,
   output logic                                 rsp_status
);

   // Commands flow down to the datapath, status flows back up.
   rstree_pkg::cmd_type  cmd;
   rstree_pkg::stat_type stat;

   // Sequence the clearing sweep, the leaf-to-root update walk and the
   // bottom-up query walk.
   rstree_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold the node store, walk registers and the output register.
   rstree_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_position    (req_position),
      .req_leaf_value  (req_leaf_value),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_range_total (rsp_range_total),
      .rsp_status      (rsp_status)
   );

endmodule

FILE: src/rstree_ctrl.sv
// ---------------------------------------------------------------------------
// rstree_ctrl
// Sequencer for clearing, leaf update walks and range query walks.
// ---------------------------------------------------------------------------
module rstree_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  rstree_pkg::stat_type stat,
   output rstree_pkg::cmd_type  cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_W_LEAF = 4'd3;
   localparam logic [3:0] S_W_RD   = 4'd4;
   localparam logic [3:0] S_W_ADD  = 4'd5;
   localparam logic [3:0] S_Q_RD   = 4'd6;
   localparam logic [3:0] S_Q_ACC  = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            priority if (stat.bad_item) state_in = S_DONE;
            else if (stat.is_query)     state_in = S_Q_RD;
            else                        state_in = S_W_LEAF;
         end
         S_W_LEAF: begin
            cmd.leaf_write = 1'b1;
            state_in       = S_W_RD;
         end
         S_W_RD: begin
            if (stat.node_is_root) begin
               state_in = S_DONE;
            end else begin
               cmd.sib_read = 1'b1;
               state_in     = S_W_ADD;
            end
         end
         S_W_ADD: begin
            cmd.parent_write = 1'b1;
            state_in         = S_W_RD;
         end
         S_Q_RD: begin
            if (stat.range_empty) begin
               state_in = S_DONE;
            end else begin
               cmd.range_read = 1'b1;
               state_in       = S_Q_ACC;
            end
         end
         S_Q_ACC: begin
            cmd.range_accum = 1'b1;
            state_in        = S_Q_RD;
         end
         S_DONE: begin
            if (stat.slot_free) begin
               cmd.result_load = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: src/rstree_dpath.sv
// ---------------------------------------------------------------------------
// rstree_dpath
// Node store, walk registers, adder and result register of the sum tree.
// ---------------------------------------------------------------------------
module rstree_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rstree_pkg::cmd_type                   cmd,
   output rstree_pkg::stat_type                  stat,
   input  logic                                  req_operation,
   input  logic        [rstree_pkg::POS_W-1:0]   req_position,
   input  logic signed [rstree_pkg::DATA_W-1:0]  req_leaf_value,
   input  logic        [rstree_pkg::POS_W-1:0]   req_range_start,
   input  logic        [rstree_pkg::POS_W-1:0]   req_range_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rstree_pkg::DATA_W-1:0]  rsp_range_total,
   output logic                                  rsp_status
);

   localparam int NW = rstree_pkg::NODE_W;
   localparam int SW = rstree_pkg::SPAN_W;
   localparam int DW = rstree_pkg::DATA_W;
   localparam int PW = rstree_pkg::POS_W;

   logic [DW-1:0] node_mem [0:rstree_pkg::TREE_NODES-1];

   logic [NW-1:0] clear_addr_ff, clear_addr_in;
   logic          op_ff, op_in;
   logic          bad_ff, bad_in;
   logic [NW-1:0] node_ff, node_in;
   logic [DW-1:0] acc_ff, acc_in;
   logic [SW-1:0] lo_ff, lo_in;
   logic [SW-1:0] hi_ff, hi_in;
   logic [DW-1:0] rd_a_ff, rd_b_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] total_ff, total_in;
   logic          status_ff, status_in;

   logic          wr_en;
   logic [NW-1:0] wr_addr;
   logic [DW-1:0] wr_data;
   logic [NW-1:0] rd_a_addr;
   logic [NW-1:0] rd_b_addr;
   logic [SW-1:0] hi_minus;
   logic [SW-1:0] leaf_node;
   logic [SW-1:0] first_node;
   logic          pos_ok;
   logic          range_ok;
   logic [DW-1:0] parent_sum;
   logic [DW-1:0] lo_term;
   logic [DW-1:0] hi_term;

   // Leaf p sits at node TREE_LEAVES + p - 1.
   assign leaf_node  = SW'(rstree_pkg::TREE_LEAVES) + SW'(req_position) - SW'(1);
   assign first_node = SW'(rstree_pkg::TREE_LEAVES) + SW'(req_range_start) - SW'(1);
   assign pos_ok     = (req_position != '0) &&
                       (req_position <= PW'(rstree_pkg::LEAF_COUNT));
   assign range_ok   = (req_range_start != '0) &&
                       (req_range_end <= PW'(rstree_pkg::LEAF_COUNT)) &&
                       (req_range_start <= req_range_end);

   assign hi_minus   = hi_ff - SW'(1);
   assign parent_sum = acc_ff + rd_a_ff;
   assign lo_term    = lo_ff[0] ? rd_a_ff : '0;
   assign hi_term    = hi_ff[0] ? rd_b_ff : '0;

   always_comb begin
      clear_addr_in = clear_addr_ff;
      op_in         = op_ff;
      bad_in        = bad_ff;
      node_in       = node_ff;
      acc_in        = acc_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      rsp_valid_in  = rsp_valid_ff;
      total_in      = total_ff;
      status_in     = status_ff;

      if (cmd.clear_step) clear_addr_in = clear_addr_ff + NW'(1);

      if (cmd.capture) begin
         op_in   = req_operation;
         bad_in  = (req_operation == rstree_pkg::OP_QUERY) ? !range_ok : !pos_ok;
         node_in = leaf_node[NW-1:0];
         acc_in  = (req_operation == rstree_pkg::OP_QUERY) ? '0 : DW'(req_leaf_value);
         lo_in   = first_node;
         hi_in   = SW'(rstree_pkg::TREE_LEAVES) + SW'(req_range_end);
      end

      if (cmd.parent_write) begin
         node_in = node_ff >> 1;
         acc_in  = parent_sum;
      end

      if (cmd.range_accum) begin
         acc_in = acc_ff + lo_term + hi_term;
         lo_in  = (lo_ff + SW'(lo_ff[0])) >> 1;
         hi_in  = (hi_ff - SW'(hi_ff[0])) >> 1;
      end

      // Free the slot on a taken beat, refill it when a result is ready.
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.result_load) begin
         rsp_valid_in = 1'b1;
         total_in     = (op_ff == rstree_pkg::OP_QUERY && !bad_ff) ? acc_ff : '0;
         status_in    = bad_ff ? rstree_pkg::ST_BAD : rstree_pkg::ST_OK;
      end
   end

   // Single write port shared by the clearing sweep and both update steps.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = node_ff;
      wr_data = acc_ff;
      priority if (cmd.clear_step) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr_ff;
         wr_data = '0;
      end else if (cmd.leaf_write) begin
         wr_en   = 1'b1;
      end else if (cmd.parent_write) begin
         wr_en   = 1'b1;
         wr_addr = node_ff >> 1;
         wr_data = parent_sum;
      end else begin
         wr_en   = 1'b0;
      end
   end

   assign rd_a_addr = cmd.sib_read ? (node_ff ^ NW'(1)) : lo_ff[NW-1:0];
   assign rd_b_addr = hi_minus[NW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) node_mem[wr_addr] <= wr_data;
      if (cmd.sib_read || cmd.range_read) rd_a_ff <= node_mem[rd_a_addr];
      if (cmd.range_read) rd_b_ff <= node_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      bad_ff    <= bad_in;
      node_ff   <= node_in;
      acc_ff    <= acc_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      total_ff  <= total_in;
      status_ff <= status_in;
   end

   assign stat.clear_done   = (clear_addr_ff == '1);
   assign stat.bad_item     = bad_ff;
   assign stat.is_query     = (op_ff == rstree_pkg::OP_QUERY);
   assign stat.node_is_root = (node_ff == NW'(1));
   assign stat.range_empty  = (lo_ff >= hi_ff);
   assign stat.slot_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_range_total = total_ff;
   assign rsp_status      = status_ff;

endmodule

FILE: src/rstree_checker.sv
// ---------------------------------------------------------------------------
// rstree_checker
// Port-level checks on the sum tree, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rstree_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 req_operation,
   input logic        [rstree_pkg::POS_W-1:0]  req_position,
   input logic signed [rstree_pkg::DATA_W-1:0] req_leaf_value,
   input logic        [rstree_pkg::POS_W-1:0]  req_range_start,
   input logic        [rstree_pkg::POS_W-1:0]  req_range_end,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [rstree_pkg::DATA_W-1:0] rsp_range_total,
   input logic                                 rsp_status
);

   logic req_beat;
   logic req_wait;
   logic rsp_stall;

   assign req_beat  = req_valid && req_ready;
   assign req_wait  = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   // Reset empties the output register.
   `ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   // One item in flight: no second beat straight after an accepted one.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_beat, !req_ready)
   // A rejected beat carries a zero total.
   `ASSERT_IMPLIES(a_bad_zero, clock, reset, rsp_valid && rsp_status,
                   rsp_range_total == '0)
   // A stalled result holds.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
                rsp_valid && $stable(rsp_range_total) && $stable(rsp_status))
   // A waiting request beat holds its payload.
   `ASSERT_NEXT(a_req_hold, clock, reset, req_wait,
                req_valid && $stable(req_operation) && $stable(req_position) &&
                $stable(req_leaf_value) && $stable(req_range_start) &&
                $stable(req_range_end))

endmodule

bind range_sum_tree_core rstree_checker u_checker (.*);
